[rtl/awis_pkg.sv]
// shared constants and types for the area weighted index sampler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package awis_pkg;

	// table size and area precision
	localparam int MAX_LIGHTS = 64;
	localparam int AREA_BITS  = 32;

	// field widths
	localparam int MODE_W    = 2;
	localparam int AREA_W    = 32;
	localparam int SAMPLE_W  = 32;
	localparam int OUT_IDX_W = 6;
	localparam int SUM_W     = 38;
	localparam int STATUS_W  = 2;

	// derived widths
	localparam int IDX_W    = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int CNT_W    = $clog2(MAX_LIGHTS + 1);
	localparam int TOT_HI_W = SUM_W - SAMPLE_W;
	localparam int LO_W     = 2 * SAMPLE_W;
	localparam int HI_W     = SAMPLE_W + TOT_HI_W;
	localparam int PROD_W   = SUM_W + SAMPLE_W;

	// stream word widths
	localparam int S_DATA_W = 64;
	localparam int S_USER_W = MODE_W;
	localparam int M_DATA_W = 48;
	localparam int M_USER_W = STATUS_W;
	localparam int M_PAD_W  = M_DATA_W - OUT_IDX_W - SUM_W;

	localparam logic [AREA_W-1:0] AREA_MASK = (AREA_BITS >= AREA_W) ? {AREA_W{1'b1}} :
		AREA_W'((64'd1 << AREA_BITS) - 64'd1);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LIGHTS);

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_DRAW   = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_LIGHTS = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_SRCH,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[rtl/awis_scale.sv]
// two-stage scaler: product of the draw fraction and the total area
// depends on awis_pkg
`timescale 1ns / 1ps
`default_nettype none

module awis_scale
	import awis_pkg::*;
(
	input  wire logic                clk,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic [SUM_W-1:0]    total,
	output logic      [PROD_W-1:0]   prod_s2
);

	logic [LO_W-1:0] lo_s1;
	logic [HI_W-1:0] hi_s1;

	// partial products: fraction times low and high part of the total
	always_ff @(posedge clk) begin
		lo_s1 <= LO_W'(sample) * LO_W'(total[SAMPLE_W-1:0]);
		hi_s1 <= HI_W'(sample) * HI_W'(total[SUM_W-1:SAMPLE_W]);
	end

	// recombine the partial products
	always_ff @(posedge clk) begin
		prod_s2 <= {hi_s1, {SAMPLE_W{1'b0}}} + PROD_W'(lo_s1);
	end

endmodule

`default_nettype wire

[rtl/area_weighted_index_sampler.sv]
// top level: running-sum table of light areas and area-weighted index draw
// depends on awis_pkg and awis_scale
//
// channel | dir | handshake          | contents
// s       | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata area and sample
// m       | out | m_tvalid/m_tready  | m_tdata index and total, m_tuser status
//
// clear, append and draw on an empty table: result registered in the cycle after
// the word is taken, one word per cycle while the output drains.
// draw: S_MUL1 and S_MUL2 scale the fraction by the total, then S_SRCH finds index k;
// the search reads one table entry per cycle through the single memory read port.
// one word in work at a time; a result waits in the output register under stall.
// reset clears count, total and control; the table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module area_weighted_index_sampler
	import awis_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // area[31:0], sample[63:32]
	input  wire logic [S_USER_W-1:0] s_tuser,  // mode[1:0]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [M_DATA_W-1:0] m_tdata,  // chosen_index[5:0], total_area[43:6], zero
	output logic      [M_USER_W-1:0] m_tuser   // status[1:0]
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    total_q;
	logic [SAMPLE_W-1:0] u_q;
	logic [IDX_W-1:0]    k_q, k_d;

	logic [SUM_W-1:0] sums_mem [MAX_LIGHTS];
	logic [SUM_W-1:0] rdata_q;

	logic [PROD_W-1:0] prod_s2;

	logic                 m_valid_q;
	logic [OUT_IDX_W-1:0] out_idx_q, out_idx_d;
	logic [SUM_W-1:0]     out_total_q, out_total_d;
	logic [STATUS_W-1:0]  out_stat_q, out_stat_d;
	logic                 load_out;

	logic [MODE_W-1:0]   in_mode;
	logic [AREA_W-1:0]   in_area;
	logic [SAMPLE_W-1:0] in_sample;
	logic                accept;
	logic                out_free;
	logic                full;
	logic                empty;
	logic                start_draw;
	logic                do_append;
	logic [SUM_W:0]      sum_wide;
	logic [SUM_W-1:0]    sum_sat;
	logic                below;
	logic                more;
	logic                step;

	// input word unpacking
	assign in_mode   = s_tuser[MODE_W-1:0];
	assign in_area   = s_tdata[AREA_W-1:0] & AREA_MASK;
	assign in_sample = s_tdata[AREA_W +: SAMPLE_W];

	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_valid_q || m_tready;
	assign full       = (count_q == CNT_FULL);
	assign empty      = (count_q == '0);
	assign start_draw = accept && (in_mode == MODE_DRAW) && !empty;
	assign do_append  = accept && (in_mode == MODE_APPEND) && !full;

	// saturating running total
	assign sum_wide = {1'b0, total_q} + (SUM_W + 1)'(in_area);
	assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

	// search compare: entry sum scaled by 2^32 against fraction times total
	assign below = {rdata_q, {SAMPLE_W{1'b0}}} < prod_s2;
	assign more  = ((CNT_W'(k_q) + CNT_W'(1)) < count_q);
	assign step  = more && below;

	awis_scale u_scale (
		.clk     (clk),
		.sample  (u_q),
		.total   (total_q),
		.prod_s2 (prod_s2)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start_draw) state_d = S_MUL1;
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_SRCH;
			S_SRCH: begin
				if (!step) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs: handshake, search address, result load
	always_comb begin
		s_tready    = 1'b0;
		k_d         = k_q;
		load_out    = 1'b0;
		out_idx_d   = '0;
		out_total_d = total_q;
		out_stat_d  = STAT_OK;
		case (state_q)
			S_IDLE: begin
				s_tready = out_free;
				k_d      = '0;
				load_out = accept && !start_draw;
				case (in_mode)
					MODE_CLEAR: out_total_d = '0;
					MODE_APPEND: begin
						if (full) out_stat_d = STAT_FULL;
						else out_total_d = sum_sat;
					end
					MODE_DRAW: out_stat_d = STAT_NO_LIGHTS;
					default: out_total_d = total_q;
				endcase
			end
			S_SRCH: begin
				if (step) k_d = k_q + IDX_W'(1);
			end
			S_DONE: begin
				load_out  = out_free;
				out_idx_d = OUT_IDX_W'(k_q);
			end
			default: k_d = k_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			total_q   <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (accept && (in_mode == MODE_CLEAR)) begin
				count_q <= '0;
				total_q <= '0;
			end else if (do_append) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= sum_sat;
			end
			if (load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// draw fraction held for the scaler
	always_ff @(posedge clk) begin
		if (start_draw) u_q <= in_sample;
	end

	// running-sum table: one write port, one registered read port
	// appends and draws never overlap, so the read needs no forwarding
	always_ff @(posedge clk) begin
		if (do_append) sums_mem[count_q[IDX_W-1:0]] <= sum_sat;
		rdata_q <= sums_mem[k_d];
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q   <= out_idx_d;
			out_total_q <= out_total_d;
			out_stat_q  <= out_stat_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_total_q, out_idx_q};
	assign m_tuser  = out_stat_q;

endmodule

`default_nettype wire

[rtl/awis_checker.sv]
// port-level checks for the area weighted index sampler, bound to the top level
// depends on awis_pkg and area_weighted_index_sampler
`timescale 1ns / 1ps
`default_nettype none

module awis_checker
	import awis_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [S_USER_W-1:0] s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic [M_USER_W-1:0] m_tuser
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	// a clear word gives an empty total with ok status on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_CLEAR) |=>
		m_tvalid && (m_tdata[OUT_IDX_W +: SUM_W] == '0) && (m_tuser == STAT_OK))
		else $error("clear did not report an empty total");

	// no lights means an empty table: index and total both zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_NO_LIGHTS) |->
		(m_tdata[OUT_IDX_W-1:0] == '0) && (m_tdata[OUT_IDX_W +: SUM_W] == '0))
		else $error("no-lights result with nonzero index or total");

	// a dropped append chooses nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata[OUT_IDX_W-1:0] == '0))
		else $error("table-full result with nonzero index");

	// input is taken only while the output slot can take its result
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input taken while a result is stalled");

endmodule

bind area_weighted_index_sampler awis_checker u_awis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
